// ===== rtl/iucc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// iucc_pkg
// Shared types and constants for the range union coverage counter.
// ----------------------------------------------------------------------------
package iucc_pkg;
  localparam int TABLE_ENTRIES = 64;
  localparam int COORD_BITS    = 30;
  localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
  localparam int CNT_BITS      = $clog2(TABLE_ENTRIES + 1);
  localparam int TOTAL_BITS    = COORD_BITS + 1;
  localparam int OUT_BITS      = 31;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [IDX_BITS-1:0]   idx_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;
  typedef logic [TOTAL_BITS-1:0] total_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;       // capture a new item, reset the scan
    logic rd_en;      // issue a table read at rd_addr
    idx_t rd_addr;
    logic absorb;     // registered read data overlaps: absorb it
    logic mark_first; // registered read data is the first kept-after entry
    logic wr_en;      // write wr_data at wr_addr
    idx_t wr_addr;
    logic wr_merged;  // write the merged range instead of read data
    logic commit;     // update count and total
  } iucc_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic   bad;     // start > end
    logic   below;   // read entry ends below the merged start
    logic   after;   // read entry starts above the merged end
    cnt_t   used;
  } iucc_sts_t;
endpackage
`default_nettype wire

// ===== rtl/iucc_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// iucc_datapath
// Range table memory, merged range registers, entry count and total.
// ----------------------------------------------------------------------------
module iucc_datapath (
  input  wire                     clk,
  input  wire                     rst,
  input  wire iucc_pkg::coord_t   in_lo,
  input  wire iucc_pkg::coord_t   in_hi,
  input  wire iucc_pkg::iucc_cmd_t cmd,
  input  wire iucc_pkg::cnt_t     new_used,
  output iucc_pkg::iucc_sts_t     sts,
  output iucc_pkg::total_t        total
);
  localparam int CW = iucc_pkg::COORD_BITS;

  logic [2*CW-1:0] mem [iucc_pkg::TABLE_ENTRIES];
  logic [2*CW-1:0] rd_data;
  iucc_pkg::coord_t lo, hi, r_lo, r_hi;
  iucc_pkg::cnt_t   used;
  iucc_pkg::total_t removed_sum;

  assign r_lo = rd_data[CW-1:0];
  assign r_hi = rd_data[2*CW-1:CW];

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= mem[cmd.rd_addr];
    end
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= cmd.wr_merged ? {hi, lo} : rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo          <= in_lo;
      hi          <= in_hi;
      removed_sum <= '0;
    end else if (cmd.absorb) begin
      if (r_lo < lo) lo <= r_lo;
      if (r_hi > hi) hi <= r_hi;
      removed_sum <= removed_sum + iucc_pkg::total_t'(r_hi - r_lo) + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= '0;
      total <= '0;
    end else if (cmd.commit) begin
      used  <= new_used;
      total <= total - removed_sum + iucc_pkg::total_t'(hi - lo) + 1'b1;
    end
  end

  assign sts.bad    = lo > hi;
  assign sts.below  = r_hi < lo;
  assign sts.after  = r_lo > hi;
  assign sts.used   = used;
endmodule
`default_nettype wire

// ===== rtl/iucc_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// iucc_controller
// Sequencer: scan the table, absorb overlaps, then shift the tail to close
// or open the gap and write the merged range.
// ----------------------------------------------------------------------------
module iucc_controller (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic                    full_flag,
  output logic                    bad_flag,
  input  wire iucc_pkg::iucc_sts_t sts,
  output iucc_pkg::iucc_cmd_t     cmd,
  output iucc_pkg::cnt_t          new_used
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DEC   = 3'd3;
  localparam logic [2:0] S_MOVE  = 3'd4;
  localparam logic [2:0] S_INS   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state, state_next;
  // scan index (one ahead of read data), first absorbed pos, last+1 pos
  iucc_pkg::cnt_t rd_i, rd_i_next, first, first_next, last, last_next;
  iucc_pkg::cnt_t mv, mv_next;
  logic           rd_pend, rd_pend_next;
  logic           full_next, bad_next;
  iucc_pkg::cnt_t removed, tail;

  assign removed  = last - first;
  assign tail     = sts.used - last;
  assign new_used = sts.used - removed + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      full_flag <= 1'b0;
      bad_flag  <= 1'b0;
    end else begin
      state <= state_next;
      full_flag <= full_next;
      bad_flag  <= bad_next;
    end
    rd_i <= rd_i_next;
    first <= first_next;
    last <= last_next;
    mv <= mv_next;
    rd_pend <= rd_pend_next;
  end

  always_comb begin
    state_next = state;
    rd_i_next = rd_i;
    first_next = first;
    last_next = last;
    mv_next = mv;
    rd_pend_next = 1'b0;
    full_next = full_flag;
    bad_next = bad_flag;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        bad_next = sts.bad;
        full_next = 1'b0;
        rd_i_next = '0;
        first_next = '0;
        last_next = '0;
        state_next = sts.bad ? S_OUT : S_SCAN;
      end
      S_SCAN: begin
        // evaluate entry rd_i-1 when its read data is back
        if (rd_pend) begin
          if (sts.below) begin
            first_next = rd_i;
            last_next = rd_i;
          end else if (!sts.after) begin
            cmd.absorb = 1'b1;
            last_next = rd_i;
          end
        end
        if (rd_pend && sts.after) begin
          state_next = S_DEC;
        end else if (rd_i < sts.used) begin
          cmd.rd_en = 1'b1;
          cmd.rd_addr = rd_i[iucc_pkg::IDX_BITS-1:0];
          rd_i_next = rd_i + 1'b1;
          rd_pend_next = 1'b1;
        end else if (!rd_pend) begin
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (removed == '0 && sts.used >= iucc_pkg::cnt_t'(iucc_pkg::TABLE_ENTRIES)) begin
          full_next = 1'b1;
          state_next = S_OUT;
        end else begin
          mv_next = (removed == '0) ? tail : '0;
          state_next = S_MOVE;
        end
      end
      S_MOVE: begin
        // removed==0: shift tail up one, from the top down
        // removed>=1: shift tail down to first+1, bottom up
        if (rd_pend) begin
          cmd.wr_en = 1'b1;
          cmd.wr_addr = (removed == '0) ?
            iucc_pkg::idx_t'(last + mv + 1'b1) :
            iucc_pkg::idx_t'(first + mv + 1'b1);
        end
        if (removed == '0) begin
          if (mv != '0) begin
            cmd.rd_en = 1'b1;
            cmd.rd_addr = iucc_pkg::idx_t'(last + mv - 1'b1);
            mv_next = mv - 1'b1;
            rd_pend_next = 1'b1;
          end else if (!rd_pend) begin
            state_next = S_INS;
          end
        end else begin
          if (rd_pend) mv_next = mv + 1'b1;
          if (mv_next < tail && !(rd_pend && mv == mv_next)) begin
            cmd.rd_en = 1'b1;
            cmd.rd_addr = iucc_pkg::idx_t'(last + mv_next);
            rd_pend_next = 1'b1;
          end else if (!rd_pend || mv_next >= tail) begin
            if (!rd_pend || mv_next >= tail) state_next = rd_pend && mv_next < tail ?
              S_MOVE : S_INS;
          end
        end
      end
      S_INS: begin
        cmd.wr_en = 1'b1;
        cmd.wr_merged = 1'b1;
        cmd.wr_addr = iucc_pkg::idx_t'(first);
        cmd.commit = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/interval_union_coverage_counter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// interval_union_coverage_counter
// Adds closed ranges to a sorted table of disjoint ranges, reports coverage.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one range per item: tdata[29:0] start, tdata[59:30] end.
//   m_axis returns one result per item: tdata[30:0] covered total,
//   tuser[0] table full (add dropped), tuser[1] bad range (start > end).
//   One item is processed at a time. An add reads the table once per stored
//   entry up to the first entry past the new range, then rewrites the tail
//   one entry per cycle through the table's read and write ports. A bad
//   range skips the scan and goes straight to its result.
//   Reset clears the entry count and the total; table contents need no clear.
//   While m_axis is stalled the result holds and no new item is taken.
// ----------------------------------------------------------------------------
module interval_union_coverage_counter (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [63:0] s_axis_tdata,   // range_start, range_end
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // covered_total
  output logic [1:0]  m_axis_tuser    // table_full, bad_range
);
  iucc_pkg::iucc_cmd_t cmd;
  iucc_pkg::iucc_sts_t sts;
  iucc_pkg::cnt_t      new_used;
  iucc_pkg::total_t    total;
  logic                full_flag, bad_flag;

  iucc_controller u_ctrl (
    .clk, .rst,
    .in_valid (s_axis_tvalid), .in_ready (s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .full_flag, .bad_flag, .sts, .cmd, .new_used
  );

  iucc_datapath u_dp (
    .clk, .rst,
    .in_lo(s_axis_tdata[29:0]), .in_hi(s_axis_tdata[59:30]),
    .cmd, .new_used, .sts, .total
  );

  assign m_axis_tdata = {1'b0, total[iucc_pkg::OUT_BITS-1:0]};
  assign m_axis_tuser = {bad_flag, full_flag};
endmodule
`default_nettype wire

// ===== tb/tb_interval_union_coverage_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_interval_union_coverage_counter
// Drives range adds into the coverage counter and checks every result against
// a local sorted-table model or a typed-in result, with random gaps, stalls.
// ----------------------------------------------------------------------------
module tb_interval_union_coverage_counter;
  localparam int N_RANDOM   = 930;
  localparam int MAX_CYCLES = 1000000;

  typedef struct packed {
    logic [30:0] total;
    logic        full;
    logic        bad;
  } cov_result_t;

  typedef struct {
    logic [29:0] lo;
    logic [29:0] hi;
    logic        chk;   // compare against the typed-in result, not the model
    cov_result_t res;
  } add_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  interval_union_coverage_counter dut (.*);

  always #4 clk = ~clk;

  // model of the range table
  longint unsigned span_lo[iucc_pkg::TABLE_ENTRIES];
  longint unsigned span_hi[iucc_pkg::TABLE_ENTRIES];
  int              span_cnt;
  longint unsigned cover_sum;
  cov_result_t     pending[$];
  int              errors = 0;
  int              cycles = 0;

  function automatic cov_result_t add_span(longint unsigned lo, longint unsigned hi);
    cov_result_t r;
    int first, last, removed, k;
    r.full = 1'b0;
    r.bad  = 1'b0;
    if (lo > hi) begin
      r.bad = 1'b1;
    end else begin
      first = 0;
      while (first < span_cnt && span_lo[first] < lo) first++;
      if (first > 0 && span_hi[first-1] >= lo) first--;
      last = first;
      while (last < span_cnt && span_lo[last] <= hi) begin
        if (span_lo[last] < lo) lo = span_lo[last];
        if (span_hi[last] > hi) hi = span_hi[last];
        cover_sum -= span_hi[last] - span_lo[last] + 1;
        last++;
      end
      removed = last - first;
      if (removed == 0 && span_cnt >= iucc_pkg::TABLE_ENTRIES) begin
        r.full = 1'b1;
      end else begin
        if (removed == 0) begin
          for (k = span_cnt; k > first; k--) begin
            span_lo[k] = span_lo[k-1];
            span_hi[k] = span_hi[k-1];
          end
        end else begin
          for (k = 0; k < span_cnt - last; k++) begin
            span_lo[first+1+k] = span_lo[last+k];
            span_hi[first+1+k] = span_hi[last+k];
          end
        end
        span_lo[first] = lo;
        span_hi[first] = hi;
        span_cnt = span_cnt - removed + 1;
        cover_sum += hi - lo + 1;
      end
    end
    r.total = cover_sum[30:0];
    return r;
  endfunction

  // directed rows: reset state, extremes, reversed, adjacency, merging
  add_row_t rows[13] = '{
    '{30'd5, 30'd4, 1'b1, '{31'd0, 1'b0, 1'b1}},
    '{30'd0, 30'd0, 1'b1, '{31'd1, 1'b0, 1'b0}},
    '{30'h3FFFFFFF, 30'h3FFFFFFF, 1'b1, '{31'd2, 1'b0, 1'b0}},
    '{30'h3FFFFFFF, 30'd0, 1'b1, '{31'd2, 1'b0, 1'b1}},
    '{30'd1, 30'd2, 1'b0, '0},
    '{30'd3, 30'd4, 1'b0, '0},
    '{30'd2, 30'd3, 1'b0, '0},
    '{30'd10, 30'd20, 1'b0, '0},
    '{30'd15, 30'd30, 1'b0, '0},
    '{30'd5, 30'd9, 1'b0, '0},
    '{30'd0, 30'h3FFFFFFF, 1'b1, '{31'h40000000, 1'b0, 1'b0}},
    '{30'd7, 30'd7, 1'b1, '{31'h40000000, 1'b0, 1'b0}},
    '{30'h2AAAAAAA, 30'h15555555, 1'b1, '{31'h40000000, 1'b0, 1'b1}}
  };

  task automatic send(logic [29:0] lo, logic [29:0] hi);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, hi, lo};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending.push_back(add_span(lo, hi));
  endtask

  task automatic send_burst_gap();
    int g;
    if ($urandom_range(0, 3) == 0) begin
      g = int'($urandom_range(1, 6));
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // check results at the accepting edge
  always @(posedge clk) begin
    cov_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending.size() == 0) begin
        $error("result with nothing pending: total %0d", m_axis_tdata[30:0]);
        errors++;
      end else begin
        want = pending.pop_front();
        if (m_axis_tdata[30:0] !== want.total) begin
          $error("covered_total expected %0d got %0d", want.total, m_axis_tdata[30:0]);
          errors++;
        end
        if (m_axis_tuser[0] !== want.full) begin
          $error("table_full expected %0b got %0b", want.full, m_axis_tuser[0]);
          errors++;
        end
        if (m_axis_tuser[1] !== want.bad) begin
          $error("bad_range expected %0b got %0b", want.bad, m_axis_tuser[1]);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern: long open stretches, then choppy phases
  always @(posedge clk) begin
    if ((cycles / 3000) % 3 == 0) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 2) != 0);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [29:0] a, b, c;
    int i, mode, width_sel;
    span_cnt = 0;
    cover_sum = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < $size(rows); i++) begin
      if (rows[i].chk) begin
        void'(add_span(rows[i].lo, rows[i].hi));
        pending.push_back(rows[i].res);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, rows[i].hi, rows[i].lo};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
      end else begin
        send(rows[i].lo, rows[i].hi);
      end
    end

    // random phase: small windows fill the table, wide ones flush it
    for (i = 0; i < N_RANDOM; i++) begin
      send_burst_gap();
      mode = int'($urandom_range(0, 99));
      if (mode < 70) begin
        // disjoint-ish small ranges in a small window: fills toward full
        a = 30'($urandom_range(0, 4000));
        width_sel = int'($urandom_range(0, 9));
        b = a + ((width_sel == 0) ? 30'd0 : 30'($urandom_range(0, 40)));
      end else if (mode < 80) begin
        a = 30'($urandom);
        b = 30'($urandom);
        if (a > b) begin c = a; a = b; b = c; end
      end else if (mode < 88) begin
        // reversed
        a = 30'($urandom);
        b = 30'($urandom);
        if (a == b) a = b + 30'd1;
        if (a < b) begin c = a; a = b; b = c; end
      end else if (mode < 93) begin
        a = 30'($urandom_range(0, 4000));
        b = a + 30'($urandom_range(50, 2000));
      end else if (mode < 96) begin
        a = 30'h3FFFFFFF - 30'($urandom_range(0, 100));
        b = 30'h3FFFFFFF;
      end else begin
        a = 30'($urandom_range(0, 30));
        b = 30'h3FFFFFFF - 30'($urandom_range(0, 30));
      end
      send(a, b);
    end
    s_axis_tvalid <= 1'b0;

    while (pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/iucc_pkg.sv
rtl/iucc_datapath.sv
rtl/iucc_controller.sv
rtl/interval_union_coverage_counter.sv
tb/tb_interval_union_coverage_counter.sv
